FILE: hdl/ccdrsf_pkg.sv
`default_nettype none

package ccdrsf_pkg;

  // Field widths
  localparam int COORD_W     = 12;
  localparam int DIM_W       = 13;
  localparam int TICK_W      = 11;
  localparam int IDX_W       = 5;
  localparam int NUM_NIBBLES = 26;
  localparam int REPLY_W     = 8;

  // Expected high nibble of the camera reply
  localparam logic [3:0] REPLY_TAG = 4'd11;
  localparam logic [5:0] SPEED_MAX = 6'd15;
  localparam logic [5:0] SPEED_MIN = 6'd1;
  localparam logic [3:0] FRAME_OPEN_NIB = 4'd1;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_REPLY = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SENSOR = 3'd1,
    ST_BAD_WINDOW = 3'd2,
    ST_TIMEOUT    = 3'd3,
    ST_REPLY_BAD  = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SENSOR_KIND = 3'd0,
    REG_BIN_X       = 3'd1,
    REG_BIN_Y       = 3'd2,
    REG_SHUTTER_SYN = 3'd3,
    REG_SHUTTER_INV = 3'd4,
    REG_AMP_OFF     = 3'd5,
    REG_READ_DELAY  = 3'd6,
    REG_LINK_SPEED  = 3'd7
  } reg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT,
    S_SINGLE
  } state_t;

  typedef struct packed {
    logic [2:0] sensor_kind;
    logic [2:0] bin_x;
    logic [2:0] bin_y;
    logic       shutter_sync;
    logic       shutter_inv;
    logic       amp_off;
    logic [3:0] read_delay;
    logic [5:0] link_speed;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic tick_inc;
    logic tick_clr;
    logic ld_reply;
    logic ld_timeout;
    logic push_nib;
    logic push_stat;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic chk_err;
    logic tick_done;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [2:0] clamp_bin(input logic [2:0] b);
    logic [2:0] r;
    r = b;
    if (b == 3'd0) r = 3'd1;
    else if (b > 3'd4) r = 3'd4;
    return r;
  endfunction

  function automatic logic [3:0] clamp_speed(input logic [5:0] s);
    logic [5:0] r;
    r = s;
    if (s > SPEED_MAX) r = SPEED_MAX;
    else if (s < SPEED_MIN) r = SPEED_MIN;
    return r[3:0];
  endfunction

  // Unbinned sensor width per kind (kinds 1..3 only)
  function automatic logic [COORD_W-1:0] sensor_width(input logic [2:0] kind);
    logic [COORD_W-1:0] r;
    case (kind)
      3'd1:    r = 12'd768;
      3'd2:    r = 12'd1536;
      3'd3:    r = 12'd2184;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Sensor width divided by the clamped binning, all quotients exact
  function automatic logic [COORD_W-1:0] binned_width(input logic [2:0] kind,
                                                      input logic [2:0] bin);
    logic [COORD_W-1:0] r;
    r = '0;
    case (kind)
      3'd1: begin
        case (bin)
          3'd2:    r = 12'd384;
          3'd3:    r = 12'd256;
          3'd4:    r = 12'd192;
          default: r = 12'd768;
        endcase
      end
      3'd2: begin
        case (bin)
          3'd2:    r = 12'd768;
          3'd3:    r = 12'd512;
          3'd4:    r = 12'd384;
          default: r = 12'd1536;
        endcase
      end
      3'd3: begin
        case (bin)
          3'd2:    r = 12'd1092;
          3'd3:    r = 12'd728;
          3'd4:    r = 12'd546;
          default: r = 12'd2184;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ccd_readout_start_framer.sv
// Start item: a capture step, a check step, then 26 results at one per cycle while
// the output is not stalled; a rejected start gives one status result after its
// capture and check. Reply and tick items give any result via the single state.
// One item in flight at a time; the output register lets the next item in while the
// last result waits. Synchronous active-low reset restores the control registers.
`default_nettype none

module ccd_readout_start_framer
  import ccdrsf_pkg::*;
#(
  parameter int TIMEOUT_TICKS     = 2000,
  parameter int FAST_CLEAR_CYCLES = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // APB configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [11:0] win_x_first, [23:12] win_x_second, [35:24] win_y_first,
  // [47:36] win_y_second, [55:48] reply_byte
  input  wire logic [55:0] in_tdata,
  // [1:0] operation
  input  wire logic [1:0]  in_tuser,
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] command_nibble, [6:4] status, [19:7] image_width,
  // [32:20] image_height, [39:33] zero
  output logic [39:0]      out_tdata,
  // [0] is_command
  output logic             out_tuser,
  output logic             out_tlast
);

  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [3:0]       nib;
  logic [2:0]       status;
  logic [DIM_W-1:0] width, height;

  ccdrsf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ccdrsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccdrsf_dp #(
    .TIMEOUT_TICKS     (TIMEOUT_TICKS),
    .FAST_CLEAR_CYCLES (FAST_CLEAR_CYCLES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .win_x_first    (in_tdata[11:0]),
    .win_x_second   (in_tdata[23:12]),
    .win_y_first    (in_tdata[35:24]),
    .win_y_second   (in_tdata[47:36]),
    .reply_byte     (in_tdata[55:48]),
    .cmd            (cmd),
    .sts            (sts),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_nibble     (nib),
    .out_is_command (out_tuser),
    .out_status     (status),
    .out_width      (width),
    .out_height     (height),
    .out_last       (out_tlast)
  );

  assign out_tdata = {7'd0, height, width, status, nib};

endmodule

`default_nettype wire

FILE: hdl/ccdrsf_cfg.sv
`default_nettype none

module ccdrsf_cfg
  import ccdrsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg        = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SENSOR_KIND: cfg_nxt.sensor_kind  = cfg_pwdata[2:0];
        REG_BIN_X:       cfg_nxt.bin_x        = cfg_pwdata[2:0];
        REG_BIN_Y:       cfg_nxt.bin_y        = cfg_pwdata[2:0];
        REG_SHUTTER_SYN: cfg_nxt.shutter_sync = cfg_pwdata[0];
        REG_SHUTTER_INV: cfg_nxt.shutter_inv  = cfg_pwdata[0];
        REG_AMP_OFF:     cfg_nxt.amp_off      = cfg_pwdata[0];
        REG_READ_DELAY:  cfg_nxt.read_delay   = cfg_pwdata[3:0];
        REG_LINK_SPEED:  cfg_nxt.link_speed   = cfg_pwdata[5:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_kind  <= 3'd1;
      cfg_r.bin_x        <= 3'd1;
      cfg_r.bin_y        <= 3'd1;
      cfg_r.shutter_sync <= 1'b1;
      cfg_r.shutter_inv  <= 1'b0;
      cfg_r.amp_off      <= 1'b1;
      cfg_r.read_delay   <= 4'd0;
      cfg_r.link_speed   <= 6'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_SENSOR_KIND: cfg_prdata = {29'd0, cfg_r.sensor_kind};
      REG_BIN_X:       cfg_prdata = {29'd0, cfg_r.bin_x};
      REG_BIN_Y:       cfg_prdata = {29'd0, cfg_r.bin_y};
      REG_SHUTTER_SYN: cfg_prdata = {31'd0, cfg_r.shutter_sync};
      REG_SHUTTER_INV: cfg_prdata = {31'd0, cfg_r.shutter_inv};
      REG_AMP_OFF:     cfg_prdata = {31'd0, cfg_r.amp_off};
      REG_READ_DELAY:  cfg_prdata = {28'd0, cfg_r.read_delay};
      REG_LINK_SPEED:  cfg_prdata = {26'd0, cfg_r.link_speed};
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/ccdrsf_dp.sv
`default_nettype none

module ccdrsf_dp
  import ccdrsf_pkg::*;
#(
  parameter int TIMEOUT_TICKS     = 2000,
  parameter int FAST_CLEAR_CYCLES = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic [COORD_W-1:0] win_x_first,
  input  wire logic [COORD_W-1:0] win_x_second,
  input  wire logic [COORD_W-1:0] win_y_first,
  input  wire logic [COORD_W-1:0] win_y_second,
  input  wire logic [REPLY_W-1:0] reply_byte,
  input  wire dp_cmd_t            cmd,
  output dp_sts_t                 sts,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [3:0]              out_nibble,
  output logic                    out_is_command,
  output logic [2:0]              out_status,
  output logic [DIM_W-1:0]        out_width,
  output logic [DIM_W-1:0]        out_height,
  output logic                    out_last
);

  // Sorted window corners
  logic [COORD_W-1:0] x_lo_r, x_hi_r, y_lo_r, y_hi_r;
  // Checked and mirrored values
  logic [COORD_W-1:0] mx1_r, mx2_r;
  logic [DIM_W-1:0]   w_r, h_r;
  status_t            st_r;
  logic [IDX_W-1:0]   idx_r;
  logic [TICK_W-1:0]  ticks_r;
  logic [TICK_W-1:0]  ticks_inc;

  // Output register
  logic               out_valid_r;
  logic [3:0]         nib_o_r;
  logic               is_cmd_o_r;
  status_t            st_o_r;
  logic [DIM_W-1:0]   w_o_r, h_o_r;
  logic               last_o_r;

  logic               kind_ok;
  logic [COORD_W-1:0] nx, nb, mx1, mx2;
  logic [2:0]         bxc, byc;
  logic               bad_win;
  status_t            chk_st;
  logic [3:0]         nib_sel;

  // Window check and x mirroring
  always_comb begin
    kind_ok = (cfg.sensor_kind == 3'd1) || (cfg.sensor_kind == 3'd2) ||
              (cfg.sensor_kind == 3'd3);
    bxc     = clamp_bin(cfg.bin_x);
    byc     = clamp_bin(cfg.bin_y);
    nx      = sensor_width(cfg.sensor_kind);
    nb      = binned_width(cfg.sensor_kind, bxc);
    // mirrored smaller x below 1 is the same as x_hi above nb
    bad_win = (x_hi_r > nx) || (y_lo_r == '0) || (x_hi_r > nb);
    mx1     = nb + COORD_W'(1) - x_hi_r;
    mx2     = nb + COORD_W'(1) - x_lo_r;
    if (!kind_ok)     chk_st = ST_BAD_SENSOR;
    else if (bad_win) chk_st = ST_BAD_WINDOW;
    else              chk_st = ST_OK;
  end

  // Command nibble sequence
  always_comb begin
    case (idx_r)
      5'd0:    nib_sel = FRAME_OPEN_NIB;
      5'd1:    nib_sel = {1'b0, cfg.sensor_kind};
      5'd2:    nib_sel = {1'b0, bxc};
      5'd3:    nib_sel = {1'b0, byc};
      5'd4:    nib_sel = mx1_r[3:0];
      5'd5:    nib_sel = mx1_r[7:4];
      5'd6:    nib_sel = mx1_r[11:8];
      5'd7:    nib_sel = mx2_r[3:0];
      5'd8:    nib_sel = mx2_r[7:4];
      5'd9:    nib_sel = mx2_r[11:8];
      5'd10:   nib_sel = y_lo_r[3:0];
      5'd11:   nib_sel = y_lo_r[7:4];
      5'd12:   nib_sel = y_lo_r[11:8];
      5'd13:   nib_sel = y_hi_r[3:0];
      5'd14:   nib_sel = y_hi_r[7:4];
      5'd15:   nib_sel = y_hi_r[11:8];
      5'd16:   nib_sel = 4'(FAST_CLEAR_CYCLES);
      5'd17:   nib_sel = {3'd0, cfg.shutter_sync};
      5'd18:   nib_sel = {3'd0, cfg.shutter_inv};
      5'd20:   nib_sel = cfg.read_delay;
      5'd21:   nib_sel = {3'd0, cfg.amp_off};
      5'd22:   nib_sel = clamp_speed(cfg.link_speed);
      default: nib_sel = 4'd0;
    endcase
  end

  assign ticks_inc     = ticks_r + TICK_W'(1);
  assign sts.chk_err   = (chk_st != ST_OK);
  assign sts.tick_done = (ticks_inc >= TICK_W'(TIMEOUT_TICKS));
  assign sts.idx_last  = (idx_r == IDX_W'(NUM_NIBBLES - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  // Item payload: corners, check results, status
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_lo_r <= (win_x_first > win_x_second) ? win_x_second : win_x_first;
      x_hi_r <= (win_x_first > win_x_second) ? win_x_first  : win_x_second;
      y_lo_r <= (win_y_first > win_y_second) ? win_y_second : win_y_first;
      y_hi_r <= (win_y_first > win_y_second) ? win_y_first  : win_y_second;
    end
    if (cmd.check) begin
      mx1_r <= mx1;
      mx2_r <= mx2;
      w_r   <= {1'b0, x_hi_r} - {1'b0, x_lo_r} + DIM_W'(1);
      h_r   <= {1'b0, y_hi_r} - {1'b0, y_lo_r} + DIM_W'(1);
      st_r  <= chk_st;
    end else if (cmd.ld_reply) begin
      st_r  <= (reply_byte[7:4] == REPLY_TAG) ? ST_OK : ST_REPLY_BAD;
    end else if (cmd.ld_timeout) begin
      st_r  <= ST_TIMEOUT;
    end
  end

  // Nibble index and tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      ticks_r <= '0;
    end else begin
      if (cmd.check)         idx_r <= '0;
      else if (cmd.push_nib) idx_r <= idx_r + IDX_W'(1);
      if (cmd.tick_clr)      ticks_r <= '0;
      else if (cmd.tick_inc) ticks_r <= ticks_inc;
    end
  end

  // Output register, loaded when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_nib || cmd.push_stat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_nib) begin
      nib_o_r    <= nib_sel;
      is_cmd_o_r <= 1'b1;
      st_o_r     <= ST_OK;
      w_o_r      <= w_r;
      h_o_r      <= h_r;
      last_o_r   <= sts.idx_last;
    end else if (cmd.push_stat) begin
      nib_o_r    <= 4'd0;
      is_cmd_o_r <= 1'b0;
      st_o_r     <= st_r;
      w_o_r      <= '0;
      h_o_r      <= '0;
      last_o_r   <= 1'b1;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_nibble     = nib_o_r;
  assign out_is_command = is_cmd_o_r;
  assign out_status     = st_o_r;
  assign out_width      = w_o_r;
  assign out_height     = h_o_r;
  assign out_last       = last_o_r;

endmodule

`default_nettype wire

FILE: hdl/ccdrsf_ctrl.sv
`default_nettype none

module ccdrsf_ctrl
  import ccdrsf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [1:0] in_op,
  input  wire dp_sts_t    sts,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   awaiting_r, awaiting_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      awaiting_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      awaiting_r <= awaiting_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    awaiting_nxt = awaiting_r;
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_op)
            OP_START: begin
              cmd.capture  = 1'b1;
              cmd.tick_clr = 1'b1;
              awaiting_nxt = 1'b0;
              state_nxt    = S_CHECK;
            end
            OP_REPLY: begin
              if (awaiting_r) begin
                cmd.ld_reply = 1'b1;
                cmd.tick_clr = 1'b1;
                awaiting_nxt = 1'b0;
                state_nxt    = S_SINGLE;
              end
            end
            OP_TICK: begin
              if (awaiting_r) begin
                if (sts.tick_done) begin
                  cmd.ld_timeout = 1'b1;
                  cmd.tick_clr   = 1'b1;
                  awaiting_nxt   = 1'b0;
                  state_nxt      = S_SINGLE;
                end else begin
                  cmd.tick_inc = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.chk_err ? S_SINGLE : S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.push_nib = 1'b1;
          if (sts.idx_last) begin
            awaiting_nxt = 1'b1;
            cmd.tick_clr = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        if (sts.out_free) begin
          cmd.push_stat = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A result is only loaded into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_nib || cmd.push_stat) |-> sts.out_free)
    else $error("result pushed into occupied output register");

  // Last nibble of a frame arms the reply wait
  a_arm_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && cmd.push_nib && sts.idx_last) |=> awaiting_r)
    else $error("reply wait not armed after frame");

  // A start in progress has dropped any earlier wait
  a_no_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK || state_r == S_EMIT) |-> !awaiting_r)
    else $error("reply wait active during frame build");

  // Rejected starts never emit command nibbles
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && sts.chk_err) |=> (state_r == S_SINGLE))
    else $error("rejected start did not go to status result");

endmodule

`default_nettype wire
